@@ src/indexed_list_insert_remove_reverse_core_assert.svh @@
// Assertion macros for the indexed list core.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef INDEXED_LIST_INSERT_REMOVE_REVERSE_CORE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_REVERSE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IDXL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define IDXL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/idxlist_pkg.sv @@
// Shared constants and types for the indexed list core.
// No dependencies; imported by indexed_list_insert_remove_reverse_core.
`default_nettype none

package idxlist_pkg;

  // Storage size and derived widths
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Stream packing
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;
  localparam int M_PAD_W   = M_TDATA_W - (VAL_W + POS_W + COUNT_W);

  // Operation codes carried on the request tuser
  typedef enum logic [KIND_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_LIST    = 2'd3
  } op_t;

  // Result status codes carried on the result tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 3'd0,
    STAT_BAD   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_ELEM  = 3'd3,
    STAT_EMPTY = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_INS,
    S_INS_PUT,
    S_SHIFT_REM,
    S_EMIT,
    S_LIST
  } state_t;

endpackage

`default_nettype wire

@@ src/indexed_list_insert_remove_reverse_core.sv @@
// Indexed list core: ordered list of signed 32-bit values kept in one synchronous memory.
// Depends on idxlist_pkg and indexed_list_insert_remove_reverse_core_assert.svh.
//
// The block holds up to DEPTH values in a one-read, one-write memory with a registered
// read port, plus an element count and an orientation flag. A request (kind on tuser)
// inserts, removes, reverses or lists. Reverse only flips the orientation flag and
// then reports, like an ignored or full request. Insert and remove move the stored
// values one entry per cycle through the memory port (a remove moves at most count-1
// elements). A list request yields one result per element, back to back while the
// result side takes them. A new request is taken once the previous one has placed
// its last result in the output register; that register parts the sides.
// The memory needs no clearing pass: only entries below the count are ever read.
`default_nettype none

`include "indexed_list_insert_remove_reverse_core_assert.svh"

module indexed_list_insert_remove_reverse_core
  import idxlist_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // list_index[6:0], value[38:7], zero pad
  input  wire logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
  // result channel
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [M_TDATA_W-1:0]  m_tdata,   // element[31:0], position[37:32],
                                                // count[44:38], zero pad
  output      logic [STATUS_W-1:0]   m_tuser,   // status[2:0]
  output      logic                  m_tlast
);

  // Value storage
  logic [VAL_W-1:0]  mem [DEPTH];
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [VAL_W-1:0]  rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;

  // Control and working registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  elem_count, elem_count_next;
  logic              rev, rev_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] tgt, tgt_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [VAL_W-1:0]  ins_val, ins_val_next;
  status_t           st, st_next;

  // Output register
  logic                out_valid_next;
  logic [VAL_W-1:0]    out_element, out_element_next;
  logic [POS_W-1:0]    out_position, out_position_next;
  logic [COUNT_W-1:0]  out_count, out_count_next;
  status_t             out_status, out_status_next;
  logic                out_last, out_last_next;
  logic                load_out;
  logic                out_free;

  // Request decode
  logic [IDX_W-1:0]  list_index;
  logic [VAL_W-1:0]  value;
  op_t               kind;
  logic              idx_end;
  logic              idx_in;
  logic [CNT_W-1:0]  idx_low;
  logic [CNT_W-1:0]  q_ins;
  logic [CNT_W-1:0]  q_rem;
  logic              is_full;
  logic [CNT_W-1:0]  phys_first;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  phys_next;

  assign list_index = s_tdata[IDX_W-1:0];
  assign value      = s_tdata[IDX_W +: VAL_W];
  assign kind       = op_t'(s_tuser);

  // Classify the index against the current count
  assign idx_end = &list_index;
  assign idx_in  = !list_index[IDX_W-1] &&
                   (COUNT_W'(list_index[IDX_W-2:0]) < COUNT_W'(elem_count));
  assign idx_low = CNT_W'(list_index[IDX_W-2:0]);
  assign is_full = (elem_count == CNT_W'(DEPTH));

  // Map logical positions to physical entries; a reversed list runs from the top down
  always_comb begin
    if (rev) begin
      q_ins = idx_end ? '0 : elem_count - idx_low;
      q_rem = idx_end ? '0 : elem_count - CNT_W'(1) - idx_low;
    end else begin
      q_ins = idx_end ? elem_count : idx_low;
      q_rem = idx_end ? elem_count - CNT_W'(1) : idx_low;
    end
  end

  assign phys_first = rev ? elem_count - CNT_W'(1) : '0;
  assign pos_inc    = CNT_W'(pos) + CNT_W'(1);
  assign phys_next  = rev ? elem_count - CNT_W'(1) - pos_inc : pos_inc;

  assign out_free = !m_tvalid || m_tready;

  // Next state, memory controls and register updates
  always_comb begin
    state_next        = state;
    elem_count_next   = elem_count;
    rev_next          = rev;
    ptr_next          = ptr;
    tgt_next          = tgt;
    pos_next          = pos;
    ins_val_next      = ins_val;
    st_next           = st;
    s_tready          = 1'b0;
    re                = 1'b0;
    raddr             = '0;
    we                = 1'b0;
    waddr             = ptr;
    wdata             = rdata;
    load_out          = 1'b0;
    out_element_next  = out_element;
    out_position_next = out_position;
    out_count_next    = out_count;
    out_status_next   = out_status;
    out_last_next     = out_last;

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ins_val_next = value;
          st_next      = STAT_DONE;
          state_next   = S_EMIT;
          case (kind)
            OP_INSERT: begin
              if (!(idx_end || idx_in)) begin
                st_next = STAT_BAD;
              end else if (is_full) begin
                st_next = STAT_FULL;
              end else begin
                elem_count_next = elem_count + CNT_W'(1);
                tgt_next        = q_ins[ADDR_W-1:0];
                ptr_next        = elem_count[ADDR_W-1:0];
                if (q_ins == elem_count) begin
                  state_next = S_INS_PUT;
                end else begin
                  // fetch the top element; it moves up one entry
                  re         = 1'b1;
                  raddr      = ADDR_W'(elem_count - CNT_W'(1));
                  state_next = S_SHIFT_INS;
                end
              end
            end
            OP_REMOVE: begin
              if (elem_count == '0 || !(idx_end || idx_in)) begin
                st_next = STAT_BAD;
              end else begin
                elem_count_next = elem_count - CNT_W'(1);
                ptr_next        = q_rem[ADDR_W-1:0];
                if (q_rem != elem_count - CNT_W'(1)) begin
                  // fetch the entry above the hole
                  re         = 1'b1;
                  raddr      = ADDR_W'(q_rem + CNT_W'(1));
                  state_next = S_SHIFT_REM;
                end
              end
            end
            OP_REVERSE: begin
              rev_next = !rev;
            end
            OP_LIST: begin
              if (elem_count == '0) begin
                st_next = STAT_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = phys_first[ADDR_W-1:0];
                pos_next   = '0;
                state_next = S_LIST;
              end
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end

      // Move entries up, from the top down to the insert point
      S_SHIFT_INS: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = rdata;
        if (ptr == tgt + ADDR_W'(1)) begin
          state_next = S_INS_PUT;
        end else begin
          re       = 1'b1;
          raddr    = ptr - ADDR_W'(2);
          ptr_next = ptr - ADDR_W'(1);
        end
      end

      // Drop the new value into the opened entry
      S_INS_PUT: begin
        we         = 1'b1;
        waddr      = tgt;
        wdata      = ins_val;
        state_next = S_EMIT;
      end

      // Move entries down over the removed one
      S_SHIFT_REM: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = rdata;
        if (CNT_W'(ptr) + CNT_W'(1) == elem_count) begin
          state_next = S_EMIT;
        end else begin
          re       = 1'b1;
          raddr    = ptr + ADDR_W'(2);
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      // Present the single result of this request
      S_EMIT: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_element_next  = '0;
          out_position_next = '0;
          out_count_next    = COUNT_W'(elem_count);
          out_status_next   = st;
          out_last_next     = 1'b1;
          state_next        = S_IDLE;
        end
      end

      // Stream elements; read the next one as the current one is loaded
      S_LIST: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_element_next  = rdata;
          out_position_next = POS_W'(pos);
          out_count_next    = COUNT_W'(elem_count);
          out_status_next   = STAT_ELEM;
          out_last_next     = (pos_inc == elem_count);
          if (pos_inc == elem_count) begin
            state_next = S_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = phys_next[ADDR_W-1:0];
            pos_next = pos + ADDR_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = load_out || (m_tvalid && !m_tready);
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Memory read port, data registered; the sweeps never read the entry being written
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      rev        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      elem_count <= elem_count_next;
      rev        <= rev_next;
      m_tvalid   <= out_valid_next;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    ptr          <= ptr_next;
    tgt          <= tgt_next;
    pos          <= pos_next;
    ins_val      <= ins_val_next;
    st           <= st_next;
    out_element  <= out_element_next;
    out_position <= out_position_next;
    out_count    <= out_count_next;
    out_status   <= out_status_next;
    out_last     <= out_last_next;
  end

  // Drive the result channel
  assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_position, out_element};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // Checks
  `IDXL_ASSERT_NOW(a_count_bound, 1'b1, elem_count <= CNT_W'(DEPTH),
                   "element count exceeds storage depth")
  `IDXL_ASSERT_NOW(a_write_state, we,
                   state == S_SHIFT_INS || state == S_INS_PUT || state == S_SHIFT_REM,
                   "memory written outside an insert or remove sweep")
  `IDXL_ASSERT_NOW(a_no_collide, re && we, raddr != waddr,
                   "sweep reads the entry it writes in the same cycle")
  `IDXL_ASSERT_NEXT(a_count_step, 1'b1,
                    elem_count == $past(elem_count) ||
                    elem_count == $past(elem_count) + CNT_W'(1) ||
                    elem_count == $past(elem_count) - CNT_W'(1),
                    "element count moved by more than one")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list core: insert, remove, reverse and list
// requests go in on the request stream, every result is predicted and checked per field.
// Depends on idxlist_pkg and indexed_list_insert_remove_reverse_core.

import idxlist_pkg::*;

// One predicted result beat
typedef struct packed {
  status_t            status;
  logic [VAL_W-1:0]   element;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] count;
  logic               last;
} list_result_t;

// Shadow copy of the list plus the queue of results still owed by the core
class list_scoreboard;
  logic [VAL_W-1:0] cells [DEPTH];
  int               n_elems;
  list_result_t     owed_q [$];
  int               errors;
  int               requests_seen;
  int               results_seen;
  int               full_hits;
  int               bad_hits;
  int               elems_listed;

  function new();
    n_elems       = 0;
    errors        = 0;
    requests_seen = 0;
    results_seen  = 0;
    full_hits     = 0;
    bad_hits      = 0;
    elems_listed  = 0;
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function void push_result(status_t st, logic [VAL_W-1:0] elem, int pos, bit last);
    list_result_t r;
    r.status   = st;
    r.element  = elem;
    r.position = pos[POS_W-1:0];
    r.count    = n_elems[COUNT_W-1:0];
    r.last     = last;
    owed_q.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue its results
  function void note_request(op_t kind, logic signed [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] value);
    int      si;
    int      slot;
    status_t st;
    logic [VAL_W-1:0] tmp;
    si = idx;
    st = STAT_DONE;
    requests_seen++;
    case (kind)
      OP_INSERT: begin
        // index 0 on an empty list falls out of the range check as well
        if (si < -1 || si >= n_elems) begin
          st = STAT_BAD;
        end else if (n_elems >= DEPTH) begin
          st = STAT_FULL;
        end else begin
          slot = (si == -1) ? n_elems : si;
          for (int i = n_elems; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = value;
          n_elems++;
        end
        push_result(st, '0, 0, 1'b1);
      end
      OP_REMOVE: begin
        if (n_elems == 0 || si < -1 || si >= n_elems) begin
          st = STAT_BAD;
        end else begin
          slot = (si == -1) ? n_elems - 1 : si;
          for (int i = slot; i + 1 < n_elems; i++) cells[i] = cells[i+1];
          n_elems--;
        end
        push_result(st, '0, 0, 1'b1);
      end
      OP_REVERSE: begin
        for (int i = 0; i < n_elems / 2; i++) begin
          tmp                   = cells[i];
          cells[i]              = cells[n_elems-1-i];
          cells[n_elems-1-i]    = tmp;
        end
        push_result(STAT_DONE, '0, 0, 1'b1);
      end
      default: begin
        if (n_elems == 0) begin
          push_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n_elems; i++)
            push_result(STAT_ELEM, cells[i], i, i + 1 == n_elems);
          elems_listed += n_elems;
        end
      end
    endcase
    if (st == STAT_FULL) full_hits++;
    if (st == STAT_BAD) bad_hits++;
  endfunction

  // Compare one accepted result beat with the oldest one owed
  task check_result(logic [STATUS_W-1:0] st, logic [VAL_W-1:0] elem,
                    logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt, logic last);
    list_result_t want;
    results_seen++;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed, status %0d", st));
    end else begin
      want = owed_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (elem !== want.element)
        report_mismatch($sformatf("element %h, want %h", elem, want.element));
      if (pos !== want.position)
        report_mismatch($sformatf("position %0d, want %0d", pos, want.position));
      if (cnt !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", cnt, want.count));
      if (last !== want.last)
        report_mismatch($sformatf("tlast %0b, want %0b", last, want.last));
    end
  endtask
endclass

module tb_top;

  localparam int RANDOM_ITEMS   = 340;
  localparam int DRAIN_AT       = 200;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT        = 130;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [IDX_W-1:0] IDX_END = '1;  // -1: end of the list

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // list_index[6:0], value[38:7], zero pad
  logic [KIND_W-1:0]    s_tuser  = '0;   // kind[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // element[31:0], position[37:32], count[44:38]
  logic [STATUS_W-1:0]  m_tuser;         // status[2:0]
  logic                 m_tlast;

  list_scoreboard sb;
  int             burst_left = 0;
  int             quiet_cycles = 0;

  indexed_list_insert_remove_reverse_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[VAL_W-1:0], m_tdata[VAL_W+POS_W-1:VAL_W],
                      m_tdata[VAL_W+POS_W+COUNT_W-1:VAL_W+POS_W], m_tlast);
  end

  // Stop the run when no request or result moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("[indexed_list_insert_remove_reverse_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random readiness in stretches, plus one long hold-off
  initial begin
    int ready_pct;
    int stretch;
    bit long_hold_done;
    ready_pct      = 100;
    stretch        = 0;
    long_hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!long_hold_done && sb.requests_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(5, 60);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        stretch--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Offer one request and hold it until accepted, then note it
  task automatic send_request(op_t kind, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W-IDX_W-VAL_W){1'b0}}, value, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(kind, idx, value);
  endtask

  task automatic hold_off(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Send in bursts of random length, most of them after a random gap
  task automatic offer(op_t kind, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
    burst_left--;
    send_request(kind, idx, value);
  endtask

  // Pick a random request; the phase biases toward filling or draining the list
  function automatic void pick_request(int phase, output op_t kind,
                                       output logic [IDX_W-1:0] idx,
                                       output logic [VAL_W-1:0] value);
    int n;
    int r;
    int si;
    int ins_w;
    int rem_w;
    n = sb.n_elems;
    case (phase)
      0:       begin ins_w = 70; rem_w = 10; end
      2:       begin ins_w = 10; rem_w = 70; end
      default: begin ins_w = 40; rem_w = 35; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w)                  kind = OP_INSERT;
    else if (r < ins_w + rem_w)     kind = OP_REMOVE;
    else if (r < ins_w + rem_w + 8) kind = OP_REVERSE;
    else                            kind = OP_LIST;
    // mostly valid positions, some past the end, some below -1
    r = $urandom_range(0, 99);
    if (r < 25)               si = -1;
    else if (r < 75 && n > 0) si = $urandom_range(0, n - 1);
    else if (r < 88)          si = $urandom_range(n, 63);
    else                      si = -int'($urandom_range(2, 64));
    idx = si[IDX_W-1:0];
    case ($urandom_range(0, 9))
      0:       value = 32'h7FFF_FFFF;
      1:       value = 32'h8000_0000;
      2:       value = 32'h0000_0000;
      3:       value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
  endfunction

  initial begin
    op_t              kind;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list cases, extremes of value and index, every operation
    offer(OP_LIST,    '0,            $urandom);
    offer(OP_REMOVE,  IDX_END,       $urandom);
    offer(OP_INSERT,  '0,            32'h1111_1111);  // front on empty: ignored
    offer(OP_REVERSE, '0,            $urandom);
    offer(OP_INSERT,  IDX_END,       32'h7FFF_FFFF);  // append to empty
    offer(OP_REMOVE,  '0,            $urandom);       // sole element: list empties
    offer(OP_INSERT,  IDX_END,       32'h8000_0000);
    offer(OP_REVERSE, '0,            $urandom);       // one element: unchanged
    offer(OP_INSERT,  '0,            32'hFFFF_FFFF);  // front
    offer(OP_INSERT,  IDX_W'(1),     32'h0000_0000);  // middle
    offer(OP_INSERT,  IDX_W'(3),     32'h2222_2222);  // index equal to count
    offer(OP_INSERT,  IDX_W'(-2),    32'h3333_3333);
    offer(OP_INSERT,  IDX_W'(-64),   32'h4444_4444);
    offer(OP_INSERT,  IDX_W'(63),    32'h5555_5555);
    offer(OP_LIST,    '0,            $urandom);
    offer(OP_REVERSE, '0,            $urandom);
    offer(OP_LIST,    IDX_END,       $urandom);
    offer(OP_REMOVE,  IDX_W'(1),     $urandom);       // middle
    offer(OP_REMOVE,  IDX_W'(5),     $urandom);
    offer(OP_REMOVE,  IDX_W'(-2),    $urandom);
    offer(OP_REMOVE,  IDX_END,       $urandom);       // last
    offer(OP_INSERT,  IDX_END,       32'h1234_5678);
    offer(OP_LIST,    '0,            $urandom);
    offer(OP_REMOVE,  IDX_W'(63),    $urandom);

    // Random: phases fill, mix, drain, mix; one pause until all results are back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      pick_request((i / 40) % 4, kind, idx, value);
      offer(kind, idx, value);
    end

    // Wait for the last results, then let the core settle
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d result beats, %0d of them listed elements",
             sb.requests_seen, sb.results_seen, sb.elems_listed);
    $display("inserts on a full store: %0d, ignored bad indices: %0d, mismatches: %0d",
             sb.full_hits, sb.bad_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("[indexed_list_insert_remove_reverse_core] OK");
    end else begin
      $display("[indexed_list_insert_remove_reverse_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/idxlist_pkg.sv
src/indexed_list_insert_remove_reverse_core.sv
tb/tb_top.sv
